[src/msp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

    localparam int FracBitsDef    = 28;
    localparam int LogTabDepthDef = 64;

    localparam logic [15:0] MaxIterReset = 16'd256;
    localparam logic [30:0] SubOffReset  = 31'd2236962;
    localparam logic [31:0] Ln2Q32       = 32'hB17217F8;

    // sub-sample coordinate: 32-bit centre plus/minus 31-bit offset
    localparam int CWidth  = 34;
    localparam int QDepth  = 2;
    localparam int CfgIdxW = 1;
    localparam int CfgDatW = 31;

    typedef enum logic [CfgIdxW-1:0] {
        RegMaxIter = 1'b0,
        RegSubOff  = 1'b1
    } t_reg;

    typedef struct packed {
        logic signed [CWidth-1:0] cr;
        logic signed [CWidth-1:0] ci;
        logic                     last;
    } t_sub;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_UPD,
        S_SQR,
        S_SQI,
        S_CHECK,
        S_NORM,
        S_IDX,
        S_INTERP,
        S_INTERP2,
        S_LNEXP,
        S_LNSUM,
        S_ADD,
        S_DIV,
        S_OUT
    } t_state;

    // ln table entry from its Q2.62 start point; elaboration only
    function automatic logic [31:0] ln_tab_entry(input logic [63:0] x0);
        logic [63:0]  x;
        logic [127:0] sq;
        logic [31:0]  l;
        logic [63:0]  t;
        x = x0;
        l = '0;
        for (int r = 0; r < 32; r++) begin
            sq = 128'(x) * 128'(x);
            x  = sq[125:62];
            l  = {l[30:0], 1'b0};
            if (x[63]) begin
                l[0] = 1'b1;
                x    = x >> 1;
            end
        end
        t = 64'(l) * 64'(Ln2Q32) + (64'(1) << 31);
        return t[63:32];
    endfunction

    function automatic logic [63:0] umag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

[src/msp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module msp_front
    import msp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_centre_re,
    input  wire logic signed [31:0] i_centre_im,
    input  wire logic        [30:0] i_sub_off,
    input  wire logic               i_full,
    output logic                    o_busy,
    output logic                    o_push,
    output t_sub                    o_data
);

    logic               r_active;
    logic [1:0]         r_i;
    logic [1:0]         r_j;
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;

    logic signed [CWidth-1:0] w_off;
    logic signed [CWidth-1:0] w_dre;
    logic signed [CWidth-1:0] w_dim;

    assign w_off = CWidth'(signed'({1'b0, i_sub_off}));

    always_comb begin
        case (r_i)
            2'd0:    w_dre = -w_off;
            2'd2:    w_dre = w_off;
            default: w_dre = '0;
        endcase
        case (r_j)
            2'd0:    w_dim = -w_off;
            2'd2:    w_dim = w_off;
            default: w_dim = '0;
        endcase
    end

    assign o_busy       = r_active;
    assign o_push       = r_active && !i_full;
    assign o_data.cr    = CWidth'(r_re) + w_dre;
    assign o_data.ci    = CWidth'(r_im) + w_dim;
    assign o_data.last  = (r_i == 2'd2) && (r_j == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else if (!r_active) begin
            if (i_start) begin
                r_active <= 1'b1;
                r_i      <= '0;
                r_j      <= '0;
                r_re     <= i_centre_re;
                r_im     <= i_centre_im;
            end
        end else if (o_push) begin
            if (r_j == 2'd2) begin
                r_j <= '0;
                if (r_i == 2'd2) begin
                    r_active <= 1'b0;
                end else begin
                    r_i <= r_i + 2'd1;
                end
            end else begin
                r_j <= r_j + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[src/msp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module msp_queue
    import msp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_sub i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_sub      o_head
);

    localparam int Aw = $clog2(QDepth);
    localparam int Cw = $clog2(QDepth + 1);

    t_sub          r_mem [QDepth];
    logic [Aw-1:0] r_wp;
    logic [Aw-1:0] r_rp;
    logic [Cw-1:0] r_cnt;

    assign o_full  = (r_cnt == Cw'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Aw'(QDepth - 1)) ? '0 : r_wp + Aw'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == Aw'(QDepth - 1)) ? '0 : r_rp + Aw'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Cw'(1);
                2'b01:   r_cnt <= r_cnt - Cw'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/msp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module msp_back
    import msp_pkg::*;
#(
    parameter int FRAC_BITS       = FracBitsDef,
    parameter int LOG_TABLE_DEPTH = LogTabDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire t_sub        i_head,
    input  wire logic [15:0] i_max_iter,
    output logic             o_pop,
    output logic             o_valid,
    output logic [30:0]      o_pixel_value
);

    localparam int IdxW = $clog2(LOG_TABLE_DEPTH + 1);
    localparam logic [127:0] Thresh = 128'(9) << (2 * FRAC_BITS);
    localparam int RShift = (FRAC_BITS <= 32) ? 32 - FRAC_BITS : 0;
    localparam int LShift = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
    localparam logic [63:0] Max31  = 64'h7FFF_FFFF;
    localparam logic [63:0] SatLim = Max31 >> LShift;
    // ceil(2^67 / 9): quotient is product >> 67, exact for any 64-bit sum
    localparam logic [63:0] RecipNine = 64'hE38E_38E3_8E38_E38F;

    logic [31:0] w_tab [LOG_TABLE_DEPTH + 1];

    genvar g;
    for (g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] X0 =
            (64'(1) << 62) + (((64'(g) << 52) / LOG_TABLE_DEPTH) << 10);
        assign w_tab[g] = ln_tab_entry(X0);
    end
    assign w_tab[LOG_TABLE_DEPTH] = Ln2Q32;

    t_state         r_state;
    t_state         n_state;
    logic [2:0]     r_step;
    logic           r_pv;
    logic [1:0]     r_sh;
    logic [63:0]    r_prod;
    logic [127:0]   r_acc;
    logic [63:0]    r_ma;
    logic [63:0]    r_mb;
    logic           r_neg;
    logic [63:0]    r_cr;
    logic [63:0]    r_ci;
    logic [63:0]    r_zr;
    logic [63:0]    r_zi;
    logic [127:0]   r_sqr;
    logic [127:0]   r_sqi;
    logic [15:0]    r_k;
    logic           r_last;
    logic [127:0]   r_norm;
    logic [6:0]     r_sc;
    logic [31:0]    r_rest;
    logic [31:0]    r_tab;
    logic [31:0]    r_diff;
    logic [63:0]    r_lnv;
    logic [63:0]    r_sample;
    logic [63:0]    r_sum;

    logic [31:0]    w_opa;
    logic [31:0]    w_opb;
    logic [63:0]    w_prod;
    logic           w_mstate;
    logic           w_mdone;
    logic [127:0]   w_mag;
    logic           w_esc;
    logic           w_limit;
    logic [63:0]    w_two;
    logic [63:0]    w_m;
    logic [63:0]    w_pc;
    logic [63:0]    w_nr;
    logic [63:0]    w_ni;
    logic [IdxW-1:0] w_idx;
    logic [63:0]    w_quot;
    logic [63:0]    w_res64;

    assign w_mstate = (r_state == S_CROSS) || (r_state == S_SQR) || (r_state == S_SQI)
                   || (r_state == S_DIV);
    assign w_mdone  = (r_step == 3'd4);
    assign w_mag    = r_sqr + r_acc;
    assign w_esc    = (w_mag >= Thresh);
    assign w_limit  = (17'(r_k) + 17'd1) >= 17'(i_max_iter);
    assign w_two    = r_zr << 1;
    assign w_m      = r_acc[FRAC_BITS +: 64];
    assign w_pc     = r_neg ? (64'd0 - w_m) : w_m;
    assign w_nr     = r_sqr[FRAC_BITS +: 64] - r_sqi[FRAC_BITS +: 64] + r_cr;
    assign w_ni     = w_pc + r_ci;
    assign w_idx    = r_prod[32 +: IdxW];
    assign w_quot   = 64'(r_acc[127:67]);

    always_comb begin
        case (r_state)
            S_CROSS, S_SQR, S_SQI, S_DIV: begin
                w_opa = r_step[1] ? r_ma[63:32] : r_ma[31:0];
                w_opb = r_step[0] ? r_mb[63:32] : r_mb[31:0];
            end
            S_IDX: begin
                w_opa = r_norm[126:95];
                w_opb = 32'(LOG_TABLE_DEPTH);
            end
            S_INTERP2: begin
                w_opa = r_diff;
                w_opb = r_rest;
            end
            S_LNEXP: begin
                w_opa = 32'(7'd127 - r_sc) - 32'(2 * FRAC_BITS);
                w_opb = Ln2Q32;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_opa) * 64'(w_opb);

    always_comb begin
        if (FRAC_BITS <= 32) begin
            w_res64 = w_quot >> RShift;
        end else if (w_quot > SatLim) begin
            w_res64 = Max31;
        end else begin
            w_res64 = w_quot << LShift;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_max_iter == '0) ? S_ADD : S_CROSS;
                end
            end
            S_CROSS:   if (w_mdone) n_state = S_UPD;
            S_UPD:     n_state = S_SQR;
            S_SQR:     if (w_mdone) n_state = S_SQI;
            S_SQI:     if (w_mdone) n_state = S_CHECK;
            S_CHECK: begin
                if (w_esc) begin
                    n_state = (r_k >= 16'd64) ? S_ADD : S_NORM;
                end else begin
                    n_state = w_limit ? S_ADD : S_CROSS;
                end
            end
            S_NORM:    if (r_norm[127]) n_state = S_IDX;
            S_IDX:     n_state = S_INTERP;
            S_INTERP:  n_state = S_INTERP2;
            S_INTERP2: n_state = S_LNEXP;
            S_LNEXP:   n_state = S_LNSUM;
            S_LNSUM:   n_state = S_ADD;
            S_ADD:     n_state = r_last ? S_DIV : S_IDLE;
            S_DIV:     if (w_mdone) n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop         = (r_state == S_IDLE) && !i_empty;
        o_valid       = (r_state == S_OUT);
        o_pixel_value = (w_res64 > Max31) ? 31'h7FFF_FFFF : w_res64[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pv    <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (w_mstate) begin
                r_step <= w_mdone ? 3'd0 : r_step + 3'd1;
                r_pv   <= !w_mdone;
            end
            case (r_state)
                S_ADD:   r_sum <= r_sum + r_sample;
                S_OUT:   r_sum <= '0;
                default: r_sum <= r_sum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_mstate) begin
            r_sh  <= 2'(r_step[1]) + 2'(r_step[0]);
            r_acc <= ((r_step == 3'd0) ? 128'd0 : r_acc)
                   + (r_pv ? (128'(r_prod) << (32 * r_sh)) : 128'd0);
        end
        case (r_state)
            S_IDLE: begin
                r_cr   <= 64'(i_head.cr);
                r_ci   <= 64'(i_head.ci);
                r_last <= i_head.last;
                r_zr   <= '0;
                r_zi   <= '0;
                r_sqr  <= '0;
                r_sqi  <= '0;
                r_k    <= '0;
                r_ma   <= '0;
                r_mb   <= '0;
                r_neg  <= 1'b0;
                r_sample <= '0;
            end
            S_UPD: begin
                r_zr <= w_nr;
                r_zi <= w_ni;
                r_ma <= umag(w_nr);
                r_mb <= umag(w_nr);
            end
            S_SQR: begin
                if (w_mdone) begin
                    r_ma <= umag(r_zi);
                    r_mb <= umag(r_zi);
                end
            end
            S_SQI: begin
                if (r_step == 3'd0) begin
                    r_sqr <= r_acc;
                end
            end
            S_CHECK: begin
                r_sqi    <= r_acc;
                r_norm   <= w_mag;
                r_sc     <= '0;
                r_sample <= '0;
                if (!w_esc && !w_limit) begin
                    r_k   <= r_k + 16'd1;
                    r_ma  <= umag(w_two);
                    r_mb  <= umag(r_zi);
                    r_neg <= w_two[63] ^ r_zi[63];
                end
            end
            S_NORM: begin
                if (!r_norm[127]) begin
                    if (r_norm[127:112] == '0) begin
                        r_norm <= r_norm << 16;
                        r_sc   <= r_sc + 7'd16;
                    end else begin
                        r_norm <= r_norm << 1;
                        r_sc   <= r_sc + 7'd1;
                    end
                end
            end
            S_INTERP: begin
                r_rest <= r_prod[31:0];
                r_tab  <= w_tab[w_idx];
                r_diff <= w_tab[w_idx + IdxW'(1)] - w_tab[w_idx];
            end
            S_LNEXP: begin
                r_lnv <= 64'(r_tab) + 64'(r_prod[63:32]);
            end
            S_LNSUM: begin
                r_sample <= (r_prod + r_lnv) >> r_k[5:0];
            end
            // divide by nine as a reciprocal multiply on the shared multiplier
            S_ADD: begin
                r_ma <= r_sum + r_sample;
                r_mb <= RecipNine;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[src/mandelbrot_supersampled_smooth_pixel.sv]
// Each of the nine sub-samples is iterated; a sample that escapes before its
// step count reaches 64 then takes a log, and the sum ends in a divide by nine.
// The single shared 32x32 multiplier sets the iteration cost.
// Throughput: one pixel at a time through the iteration unit; start is taken
// again once the nine sub-samples are queued. The receiver cannot stall.
// Reset: synchronous active low; registers return to 256 and 2236962.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_supersampled_smooth_pixel
    import msp_pkg::*;
#(
    parameter int FRAC_BITS       = FracBitsDef,
    parameter int LOG_TABLE_DEPTH = LogTabDepthDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_centre_re,
    input  wire logic signed [31:0] i_centre_im,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [CfgDatW-1:0] i_cfg_data,
    output logic                    o_valid,
    output logic [30:0]             o_pixel_value
);

    logic [15:0] r_max_iter;
    logic [30:0] r_sub_off;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_sub w_qin;
    t_sub w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MaxIterReset;
            r_sub_off  <= SubOffReset;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                RegMaxIter: r_max_iter <= i_cfg_data[15:0];
                RegSubOff:  r_sub_off  <= i_cfg_data;
                default:    r_max_iter <= r_max_iter;
            endcase
        end
    end

    msp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_centre_re (i_centre_re),
        .i_centre_im (i_centre_im),
        .i_sub_off   (r_sub_off),
        .i_full      (w_full),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_data      (w_qin)
    );

    msp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    msp_back #(
        .FRAC_BITS       (FRAC_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .i_max_iter    (r_max_iter),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_pixel_value (o_pixel_value)
    );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import msp_pkg::*;

    localparam int FRAC      = FracBitsDef;
    localparam int DEPTH     = LogTabDepthDef;
    localparam int WDOG_MAX  = 400000;
    localparam int TAIL_WAIT = 200;
    localparam int ONE       = 1 << FRAC;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [31:0]       i_centre_re = '0;
    logic signed [31:0]       i_centre_im = '0;
    logic                     i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_idx = '0;
    logic [CfgDatW-1:0]       i_cfg_data = '0;
    logic                     o_valid;
    logic [30:0]              o_pixel_value;

    logic [63:0] ln_table [0:DEPTH];
    logic [15:0] iter_limit = MaxIterReset;
    logic [30:0] offset_q   = SubOffReset;
    logic [30:0] pending_pixels [$];
    int          n_errors = 0;
    int          idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    mandelbrot_supersampled_smooth_pixel u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_centre_re   (i_centre_re),
        .i_centre_im   (i_centre_im),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_pixel_value (o_pixel_value)
    );

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        m = p[FRAC+63:FRAC];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [127:0] square_mag(input longint v);
        return {64'd0, magnitude(v)} * {64'd0, magnitude(v)};
    endfunction

    task automatic build_ln_table();
        logic [63:0]  x;
        logic [127:0] sq;
        logic [63:0]  frac_l;
        for (int i = 0; i < DEPTH; i++) begin
            x = (64'd1 << 62) + (((64'(i) << 52) / DEPTH) << 10);
            frac_l = '0;
            for (int r = 0; r < 32; r++) begin
                sq = {64'd0, x} * {64'd0, x};
                x = sq[125:62];
                frac_l = frac_l << 1;
                if (x[63]) begin
                    frac_l[0] = 1'b1;
                    x = x >> 1;
                end
            end
            ln_table[i] = (frac_l * 64'(Ln2Q32) + (64'd1 << 31)) >> 32;
        end
        ln_table[DEPTH] = 64'(Ln2Q32);
    endtask

    // natural log in Q.32 of |z|^2 held with 2*FRAC fraction bits
    function automatic logic [63:0] log_q32(input logic [127:0] v);
        int           p;
        logic [127:0] n;
        logic [31:0]  f;
        logic [63:0]  u, idx, rest, diff, lnv;
        p = 0;
        for (int b = 127; b >= 0; b--) begin
            if (v[b]) begin
                p = b;
                break;
            end
        end
        n = v << (127 - p);
        f = n[126:95];
        u = 64'(f) * DEPTH;
        idx = u >> 32;
        rest = u & 64'hFFFF_FFFF;
        diff = ln_table[idx+1] - ln_table[idx];
        lnv = ln_table[idx] + ((diff * rest) >> 32);
        return 64'(p - 2 * FRAC) * 64'(Ln2Q32) + lnv;
    endfunction

    function automatic logic [63:0] escape_value(input longint cr, input longint ci);
        longint       zr, zi, nr, ni;
        logic [127:0] mag2, bound;
        zr = 0;
        zi = 0;
        bound = 128'd9 << (2 * FRAC);
        for (int k = 0; k < int'(iter_limit); k++) begin
            nr = fix_mul(zr, zr) - fix_mul(zi, zi) + cr;
            ni = fix_mul(2 * zr, zi) + ci;
            zr = nr;
            zi = ni;
            mag2 = square_mag(zr) + square_mag(zi);
            if (mag2 >= bound)
                return (k >= 64) ? 64'd0 : (log_q32(mag2) >> k);
        end
        return 64'd0;
    endfunction

    function automatic logic [30:0] smooth_pixel(input logic signed [31:0] re,
                                                 input logic signed [31:0] im);
        logic [63:0] sum, avg, res;
        longint      off;
        sum = '0;
        off = longint'(offset_q);
        for (int i = -1; i < 2; i++)
            for (int j = -1; j < 2; j++)
                sum += escape_value(longint'(re) + i * off, longint'(im) + j * off);
        avg = sum / 9;
        res = avg >> (32 - FRAC);
        if (res > 64'h7FFF_FFFF)
            res = 64'h7FFF_FFFF;
        return res[30:0];
    endfunction

    task automatic write_reg(input t_reg idx, input logic [30:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == RegMaxIter)
            iter_limit = value[15:0];
        else
            offset_q = value;
    endtask

    // start stays high on a zero gap; settle() must follow the last send
    task automatic send_pixel(input logic signed [31:0] re, input logic signed [31:0] im);
        int gap;
        start       <= 1'b1;
        i_centre_re <= re;
        i_centre_im <= im;
        do @(posedge i_clk); while (busy);
        pending_pixels.insert(pending_pixels.size(), smooth_pixel(re, im));
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] near_set_re();
        return $signed($urandom_range(0, 5 * ONE / 2)) - 2 * ONE;
    endfunction

    function automatic logic signed [31:0] near_set_im();
        return $signed($urandom_range(0, 5 * ONE / 2)) - 5 * ONE / 4;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_value: unexpected word %0h", o_pixel_value);
                n_errors++;
            end else begin
                if (o_pixel_value !== pending_pixels[0]) begin
                    $error("pixel_value: expected %0h actual %0h",
                           pending_pixels[0], o_pixel_value);
                    n_errors++;
                end
                void'(pending_pixels.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL mandelbrot_supersampled_smooth_pixel");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_pixel(32'sd0, 32'sd0);
        send_pixel(-32'sd1 * ONE, 32'sd0);
        send_pixel(32'sd1 * ONE, 32'sd1 * ONE);
        settle();
    endtask

    task automatic test_field_extremes();
        write_reg(RegMaxIter, 31'd65535);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(32'h8000_0000, 32'h8000_0000);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(32'sd5 * ONE, -32'sd5 * ONE);
        settle();
    endtask

    task automatic test_zero_iterations();
        write_reg(RegMaxIter, 31'd0);
        send_pixel(32'sd0, 32'sd0);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
        settle();
        write_reg(RegMaxIter, 31'd1);
        send_pixel(32'sd0, 32'sd0);
        send_pixel(32'sd3 * ONE, 32'sd0);
        settle();
    endtask

    // just right of the cusp at 0.25: escapes after many steps
    task automatic test_late_escape();
        write_reg(RegMaxIter, 31'd256);
        write_reg(RegSubOff, 31'd0);
        send_pixel(32'(ONE / 4 + ONE / 1000), 32'sd0);
        send_pixel(32'(ONE / 4 + ONE / 200), 32'sd0);
        send_pixel(32'(ONE / 4 + ONE / 20), 32'sd0);
        settle();
    endtask

    task automatic test_offset_extremes();
        write_reg(RegMaxIter, 31'd12);
        write_reg(RegSubOff, 31'h7FFF_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(32'h8000_0000, 32'h8000_0000);
        send_pixel(32'sd0, 32'sd0);
        settle();
        write_reg(RegSubOff, 31'h5555_5555);
        send_pixel(32'sd0, 32'sd0);
        settle();
        write_reg(RegSubOff, 31'h2AAA_AAAA);
        send_pixel(-32'sd1 * ONE, 32'sd1 * ONE);
        settle();
    endtask

    task automatic test_random();
        logic signed [31:0] re, im;
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(RegMaxIter, 31'($urandom_range(1, 18)));
            case ($urandom_range(0, 3))
                0: write_reg(RegSubOff, 31'($urandom()));
                1: write_reg(RegSubOff, 31'($urandom_range(0, ONE / 8)));
                default: write_reg(RegSubOff, 31'($urandom_range(0, ONE / 64)));
            endcase
            for (int n = 0; n < 24; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    re = near_set_re();
                    im = near_set_im();
                end else begin
                    re = $urandom();
                    im = $urandom();
                end
                send_pixel(re, im);
            end
            settle();
        end
    endtask

    initial begin
        build_ln_table();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_field_extremes();
        test_zero_iterations();
        test_late_escape();
        test_offset_extremes();
        test_random();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (n_errors == 0 && pending_pixels.size() == 0)
            $display("PASS mandelbrot_supersampled_smooth_pixel");
        else
            $display("FAIL mandelbrot_supersampled_smooth_pixel");
        $finish;
    end

endmodule
